// File: rtl/core/mtm_pkg.sv
// Shared types, constants and helpers for the motor to transform matrix block.
// No dependencies; imported by mtm_mul_rnd and motor_to_transform_matrix.
package mtm_pkg;

	localparam int NUM_PROD = 21;
	localparam int NUM_OUT  = 12;
	localparam int COMP_W   = 32;
	localparam int PROD_W   = 2 * COMP_W;
	localparam int RND_W    = 34;
	localparam int SUM_W    = 35;
	localparam int ACC_W    = 38;
	localparam int FRAC_SH  = 30;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	localparam prod_t RND_HALF = prod_t'(64'sd1 <<< (FRAC_SH - 1));
	localparam acc_t  Q30_ONE  = acc_t'(38'sd1 <<< FRAC_SH);
	localparam acc_t  SAT_MAX  = acc_t'(38'sd2147483647);
	localparam acc_t  SAT_MIN  = acc_t'(-38'sd2147483648);

	// Load enables for the two multiplier stages
	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	function automatic comp_t sat32(input acc_t v);
		comp_t r;
		if (v > SAT_MAX) begin
			r = comp_t'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			r = comp_t'(SAT_MIN);
		end else begin
			r = v[COMP_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/mtm_mul_rnd.sv
// Two-stage signed 32x32 multiplier with round-half-up by 30 fraction bits.
// Depends on mtm_pkg.
module mtm_mul_rnd (
	input  logic              clk,
	input  mtm_pkg::stage_en_t en,
	input  mtm_pkg::comp_t    a,
	input  mtm_pkg::comp_t    b,
	output mtm_pkg::rnd_t     q
);
	import mtm_pkg::*;

	prod_t prod_s1;
	prod_t biased;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= a * b;
		end
	end

	assign biased = prod_s1 + RND_HALF;

	// drop 30 fraction bits; the rounded value always fits 34 bits
	always_ff @(posedge clk) begin
		if (en.s2) begin
			q <= biased[PROD_W-1:FRAC_SH];
		end
	end

endmodule

// File: rtl/core/motor_to_transform_matrix.sv
// Top level of the motor to 3x4 rigid transform matrix converter.
// Depends on mtm_pkg and mtm_mul_rnd.
//
// Takes one motor per request (rotor x, y, z, w in Q1.30, screw x, y, z, w in
// Q15.16, plus a forward/inverse flag on tuser) and returns the twelve matrix
// entries m00 m01 m02 t0 m10 m11 m12 t1 m20 m21 m22 t2, rotation entries in
// Q1.30 and translation entries in Q15.16, each saturated to 32 bits. One
// motor is accepted every clock cycle while the output does not stall; the
// fourth stage writes the output register. The four stages are:
// 21 parallel 32x32 products,
// rounding of each product by 30 fraction bits, pairwise sums with the sign
// flip for the inverse, and the final doubling, offset and saturation into
// the output register. Every stage holds its own valid bit, so a stall on the
// output only backs up the stages that are full and bubbles are squeezed out.
// The rotor is not normalized; entries simply saturate when it is too large.
module motor_to_transform_matrix (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] rot_x, [63:32] rot_y, [95:64] rot_z, [127:96] rot_w,
	// [159:128] screw_x, [191:160] screw_y, [223:192] screw_z, [255:224] screw_w
	input  logic [255:0] s_axis_tdata,
	// [0] cmd (0 forward, 1 inverse)
	input  logic [0:0]   s_axis_tuser,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] m00, [63:32] m01, [95:64] m02, [127:96] t0,
	// [159:128] m10, [191:160] m11, [223:192] m12, [255:224] t1,
	// [287:256] m20, [319:288] m21, [351:320] m22, [383:352] t2
	output logic [383:0] m_axis_tdata
);
	import mtm_pkg::*;

	// Product slots
	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_XY = 3;
	localparam int P_ZX = 4;
	localparam int P_YZ = 5;
	localparam int P_ZW = 6;
	localparam int P_YW = 7;
	localparam int P_XW = 8;
	localparam int P_Y_SZ = 9;
	localparam int P_Z_SY = 10;
	localparam int P_Z_SX = 11;
	localparam int P_X_SZ = 12;
	localparam int P_X_SY = 13;
	localparam int P_Y_SX = 14;
	localparam int P_SX_W = 15;
	localparam int P_X_SW = 16;
	localparam int P_SY_W = 17;
	localparam int P_Y_SW = 18;
	localparam int P_SZ_W = 19;
	localparam int P_Z_SW = 20;

	// Unpack the request
	comp_t rx, ry, rz, rw, sx, sy, sz, sw;
	assign rx = s_axis_tdata[31:0];
	assign ry = s_axis_tdata[63:32];
	assign rz = s_axis_tdata[95:64];
	assign rw = s_axis_tdata[127:96];
	assign sx = s_axis_tdata[159:128];
	assign sy = s_axis_tdata[191:160];
	assign sz = s_axis_tdata[223:192];
	assign sw = s_axis_tdata[255:224];

	// Stage handshake: a stage loads when it is empty or its successor loads
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	stage_en_t mul_en;

	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign mul_en = '{s1: en1, s2: en2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Carry the inverse flag alongside the products
	logic cmd_s1, cmd_s2;

	always_ff @(posedge clk) begin
		if (en1) cmd_s1 <= s_axis_tuser[0];
		if (en2) cmd_s2 <= cmd_s1;
	end

	// Stages 1 and 2: all products, each rounded by 30 fraction bits
	comp_t op_a [NUM_PROD];
	comp_t op_b [NUM_PROD];
	rnd_t  prod_s2 [NUM_PROD];

	always_comb begin
		op_a[P_XX] = rx;  op_b[P_XX] = rx;
		op_a[P_YY] = ry;  op_b[P_YY] = ry;
		op_a[P_ZZ] = rz;  op_b[P_ZZ] = rz;
		op_a[P_XY] = rx;  op_b[P_XY] = ry;
		op_a[P_ZX] = rz;  op_b[P_ZX] = rx;
		op_a[P_YZ] = ry;  op_b[P_YZ] = rz;
		op_a[P_ZW] = rz;  op_b[P_ZW] = rw;
		op_a[P_YW] = ry;  op_b[P_YW] = rw;
		op_a[P_XW] = rx;  op_b[P_XW] = rw;
		op_a[P_Y_SZ] = ry;  op_b[P_Y_SZ] = sz;
		op_a[P_Z_SY] = rz;  op_b[P_Z_SY] = sy;
		op_a[P_Z_SX] = rz;  op_b[P_Z_SX] = sx;
		op_a[P_X_SZ] = rx;  op_b[P_X_SZ] = sz;
		op_a[P_X_SY] = rx;  op_b[P_X_SY] = sy;
		op_a[P_Y_SX] = ry;  op_b[P_Y_SX] = sx;
		op_a[P_SX_W] = sx;  op_b[P_SX_W] = rw;
		op_a[P_X_SW] = rx;  op_b[P_X_SW] = sw;
		op_a[P_SY_W] = sy;  op_b[P_SY_W] = rw;
		op_a[P_Y_SW] = ry;  op_b[P_Y_SW] = sw;
		op_a[P_SZ_W] = sz;  op_b[P_SZ_W] = rw;
		op_a[P_Z_SW] = rz;  op_b[P_Z_SW] = sw;
	end

	for (genvar i = 0; i < NUM_PROD; i++) begin : g_mul
		mtm_mul_rnd u_mul (
			.clk (clk),
			.en  (mul_en),
			.a   (op_a[i]),
			.b   (op_b[i]),
			.q   (prod_s2[i])
		);
	end

	// Stage 3: diagonal sums, cross terms, and the sign flip for the inverse
	sum_t d0_s3, d1_s3, d2_s3;
	sum_t a0_s3, a1_s3, a2_s3, b0_s3, b1_s3, b2_s3;
	rnd_t xy_s3, zx_s3, yz_s3, zw_s3, yw_s3, xw_s3;

	sum_t b0_nx, b1_nx, b2_nx;
	assign b0_nx = sum_t'(prod_s2[P_SX_W]) - sum_t'(prod_s2[P_X_SW]);
	assign b1_nx = sum_t'(prod_s2[P_SY_W]) - sum_t'(prod_s2[P_Y_SW]);
	assign b2_nx = sum_t'(prod_s2[P_SZ_W]) - sum_t'(prod_s2[P_Z_SW]);

	always_ff @(posedge clk) begin
		if (en3) begin
			d0_s3 <= sum_t'(prod_s2[P_YY]) + sum_t'(prod_s2[P_ZZ]);
			d1_s3 <= sum_t'(prod_s2[P_ZZ]) + sum_t'(prod_s2[P_XX]);
			d2_s3 <= sum_t'(prod_s2[P_XX]) + sum_t'(prod_s2[P_YY]);
			a0_s3 <= sum_t'(prod_s2[P_Y_SZ]) - sum_t'(prod_s2[P_Z_SY]);
			a1_s3 <= sum_t'(prod_s2[P_Z_SX]) - sum_t'(prod_s2[P_X_SZ]);
			a2_s3 <= sum_t'(prod_s2[P_X_SY]) - sum_t'(prod_s2[P_Y_SX]);
			xy_s3 <= prod_s2[P_XY];
			zx_s3 <= prod_s2[P_ZX];
			yz_s3 <= prod_s2[P_YZ];
			// inverse: flip the antisymmetric terms
			zw_s3 <= cmd_s2 ? -prod_s2[P_ZW] : prod_s2[P_ZW];
			yw_s3 <= cmd_s2 ? -prod_s2[P_YW] : prod_s2[P_YW];
			xw_s3 <= cmd_s2 ? -prod_s2[P_XW] : prod_s2[P_XW];
			b0_s3 <= cmd_s2 ? -b0_nx : b0_nx;
			b1_s3 <= cmd_s2 ? -b1_nx : b1_nx;
			b2_s3 <= cmd_s2 ? -b2_nx : b2_nx;
		end
	end

	// Stage 4: double, offset the diagonal by one, saturate into the output
	acc_t ent [NUM_OUT];

	always_comb begin
		ent[0]  = Q30_ONE - (acc_t'(d0_s3) <<< 1);
		ent[1]  = (acc_t'(xy_s3) - acc_t'(zw_s3)) <<< 1;
		ent[2]  = (acc_t'(zx_s3) + acc_t'(yw_s3)) <<< 1;
		ent[3]  = (acc_t'(a0_s3) + acc_t'(b0_s3)) <<< 1;
		ent[4]  = (acc_t'(xy_s3) + acc_t'(zw_s3)) <<< 1;
		ent[5]  = Q30_ONE - (acc_t'(d1_s3) <<< 1);
		ent[6]  = (acc_t'(yz_s3) - acc_t'(xw_s3)) <<< 1;
		ent[7]  = (acc_t'(a1_s3) + acc_t'(b1_s3)) <<< 1;
		ent[8]  = (acc_t'(zx_s3) - acc_t'(yw_s3)) <<< 1;
		ent[9]  = (acc_t'(yz_s3) + acc_t'(xw_s3)) <<< 1;
		ent[10] = Q30_ONE - (acc_t'(d2_s3) <<< 1);
		ent[11] = (acc_t'(a2_s3) + acc_t'(b2_s3)) <<< 1;
	end

	logic [NUM_OUT-1:0][COMP_W-1:0] out_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int k = 0; k < NUM_OUT; k++) begin
				out_s4[k] <= sat32(ent[k]);
			end
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = out_s4;

endmodule
